>>> rtl/rrr_pkg.sv
package rrr_pkg;

   localparam int unsigned PAYLOAD_BYTES   = 1024;
   localparam int unsigned EVENT_TYPE_MAX  = 63;
   localparam int unsigned RESOURCE_BUFFER = 256;

   localparam int unsigned HDR_BYTES    = 32;
   localparam int unsigned PREFIX_BYTES = 4;
   localparam int unsigned BODY_CAP     = 8192;
   localparam int unsigned LEN_SAT      = 16383;
   localparam int unsigned MAX_BODY_RESET = 8192;

   localparam logic CSR_PEER_CONFIRMED  = 1'b0;
   localparam logic CSR_MAX_BODY_LENGTH = 1'b1;

   typedef enum logic [2:0] {
      KIND_HEADER   = 3'd0,
      KIND_TYPE     = 3'd1,
      KIND_RESOURCE = 3'd2,
      KIND_PAYLOAD  = 3'd3,
      KIND_ERROR    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_NEW             = 3'd0,
      STATUS_DUPLICATE       = 3'd1,
      STATUS_PEER_UNVERIFIED = 3'd2,
      STATUS_BAD_FRAME_LEN   = 3'd3,
      STATUS_MALFORMED       = 3'd4
   } status_type;

   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic [7:0]  out_byte;
      logic [63:0] record_offset;
      logic [63:0] event_id_high;
      logic [63:0] event_id_low;
      logic [10:0] payload_length;
      logic [5:0]  type_length;
      logic [7:0]  resource_length;
      logic [31:0] applied_count;
      logic [31:0] duplicate_count;
      logic        last;
   } result_type;

endpackage

>>> rtl/rrr_out_skid.sv
module rrr_out_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  rrr_pkg::result_type push_data,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rrr_pkg::result_type rsp_data
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   rrr_pkg::result_type main_ff, main_in;
   rrr_pkg::result_type skid_ff, skid_in;
   logic                pop;

   assign pop = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push_valid) begin
            main_in = push_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         if (!main_valid_ff) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   // The skid entry is only ever filled behind a waiting main entry.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry valid without main entry");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !skid_valid_ff)
      else $error("result pushed while skid entry is occupied");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> !skid_valid_ff)
      else $error("skid entry not drained after a taken beat");

endmodule

>>> rtl/replication_record_receiver.sv
// Each result is registered in the output buffer's main or skid entry before it reaches rsp.
// Throughput: one req beat per cycle while req_stall is low; the last header byte and
// every content byte produce one result, as does the byte that fails the session; other
// bytes produce none. req_stall rises only while the two-entry output buffer is full.
// Synchronous reset clears the parser, cursor, counters and failed flag, clears the
// peer flag and sets max_body_length to 8192.
module replication_record_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_out_byte,
   output logic [63:0] rsp_record_offset,
   output logic [63:0] rsp_event_id_high,
   output logic [63:0] rsp_event_id_low,
   output logic [10:0] rsp_payload_length,
   output logic [5:0]  rsp_type_length,
   output logic [7:0]  rsp_resource_length,
   output logic [31:0] rsp_applied_count,
   output logic [31:0] rsp_duplicate_count,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [13:0] csr_write_data
);

   logic        peer_ff;
   logic [13:0] max_body_ff;

   logic [13:0] pos_ff, pos_in;
   logic [13:0] body_ff, body_in;
   logic [63:0] offset_ff, offset_in;
   logic [63:0] id_low_ff, id_low_in;
   logic [63:0] id_high_ff, id_high_in;
   logic [15:0] pl_len_ff, pl_len_in;
   logic [7:0]  type_len_ff, type_len_in;
   logic [7:0]  res_len_ff, res_len_in;
   logic        dup_ff, dup_in;
   logic [63:0] cursor_ff, cursor_in;
   logic [31:0] applied_ff, applied_in;
   logic [31:0] dups_ff, dups_in;
   logic        failed_ff, failed_in;

   logic                accept;
   logic                push_valid;
   rrr_pkg::result_type push_data;
   rrr_pkg::result_type rsp_data;
   logic                buf_full;

   logic                do_fail;
   rrr_pkg::status_type fail_status;
   logic [13:0]         limit;
   logic [4:0]          hb;
   logic [13:0]         content_index;
   logic [8:0]          type_res_sum;
   logic [16:0]         declared_body;
   logic                malformed;
   logic                rec_last;

   assign req_stall = buf_full;
   assign accept    = req_valid && !req_stall;

   assign limit = (max_body_ff > 14'(rrr_pkg::BODY_CAP)) ? 14'(rrr_pkg::BODY_CAP)
                                                          : max_body_ff;
   assign hb            = 5'(pos_ff - 14'(rrr_pkg::PREFIX_BYTES));
   assign content_index = pos_ff - 14'(rrr_pkg::PREFIX_BYTES + rrr_pkg::HDR_BYTES);
   assign type_res_sum  = {1'b0, type_len_ff} + {1'b0, res_len_ff};
   assign declared_body = 17'(rrr_pkg::HDR_BYTES) + {8'h00, type_res_sum}
                          + {1'b0, pl_len_ff};
   assign malformed = (pl_len_ff > 16'(rrr_pkg::PAYLOAD_BYTES))
                   || (type_len_ff > 8'(rrr_pkg::EVENT_TYPE_MAX))
                   || ({1'b0, res_len_ff} >= 9'(rrr_pkg::RESOURCE_BUFFER))
                   || ({3'b000, body_ff} != declared_body);

   always_comb begin
      pos_in      = pos_ff;
      body_in     = body_ff;
      offset_in   = offset_ff;
      id_low_in   = id_low_ff;
      id_high_in  = id_high_ff;
      pl_len_in   = pl_len_ff;
      type_len_in = type_len_ff;
      res_len_in  = res_len_ff;
      dup_in      = dup_ff;
      cursor_in   = cursor_ff;
      applied_in  = applied_ff;
      dups_in     = dups_ff;
      failed_in   = failed_ff;
      do_fail     = 1'b0;
      fail_status = rrr_pkg::STATUS_NEW;
      rec_last    = 1'b0;
      push_valid  = 1'b0;

      push_data.kind            = rrr_pkg::KIND_HEADER;
      push_data.status          = rrr_pkg::STATUS_NEW;
      push_data.out_byte        = 8'h00;
      push_data.record_offset   = offset_ff;
      push_data.event_id_high   = id_high_ff;
      push_data.event_id_low    = id_low_ff;
      push_data.payload_length  = pl_len_ff[10:0];
      push_data.type_length     = type_len_ff[5:0];
      push_data.resource_length = res_len_ff;
      push_data.applied_count   = applied_ff;
      push_data.duplicate_count = dups_ff;
      push_data.last            = 1'b0;

      if (accept && !failed_ff) begin
         if (!peer_ff) begin
            do_fail     = 1'b1;
            fail_status = rrr_pkg::STATUS_PEER_UNVERIFIED;
         end else if (pos_ff < 14'(rrr_pkg::PREFIX_BYTES)) begin
            if (pos_ff == 14'd0) begin
               body_in     = {6'b000000, req_in_byte};
               offset_in   = '0;
               id_low_in   = '0;
               id_high_in  = '0;
               pl_len_in   = '0;
               type_len_in = '0;
               res_len_in  = '0;
               dup_in      = 1'b0;
            end else if (body_ff != 14'(rrr_pkg::LEN_SAT)) begin
               if (pos_ff == 14'd1 && req_in_byte <= 8'h3f) begin
                  body_in = body_ff | {req_in_byte[5:0], 8'h00};
               end else if (req_in_byte != 8'h00) begin
                  body_in = 14'(rrr_pkg::LEN_SAT);
               end
            end
            if (pos_ff == 14'(rrr_pkg::PREFIX_BYTES - 1)
                && (body_in < 14'(rrr_pkg::HDR_BYTES) || body_in > limit)) begin
               do_fail     = 1'b1;
               fail_status = rrr_pkg::STATUS_BAD_FRAME_LEN;
            end else begin
               pos_in = pos_ff + 14'd1;
            end
         end else if (pos_ff < 14'(rrr_pkg::PREFIX_BYTES + rrr_pkg::HDR_BYTES)) begin
            unique case (hb[4:3])
               2'd0: offset_in[{hb[2:0], 3'b000} +: 8] = req_in_byte;
               2'd1: id_low_in[{hb[2:0], 3'b000} +: 8] = req_in_byte;
               2'd2: id_high_in[{hb[2:0], 3'b000} +: 8] = req_in_byte;
               default: begin
                  unique case (hb[2:0])
                     3'd0:    pl_len_in = {8'h00, req_in_byte};
                     3'd1:    pl_len_in[15:8] = req_in_byte;
                     3'd2:    type_len_in = req_in_byte;
                     3'd3:    res_len_in = req_in_byte;
                     default: ;
                  endcase
               end
            endcase
            if (hb != 5'(rrr_pkg::HDR_BYTES - 1)) begin
               pos_in = pos_ff + 14'd1;
            end else if (malformed) begin
               do_fail     = 1'b1;
               fail_status = rrr_pkg::STATUS_MALFORMED;
            end else begin
               if (offset_ff < cursor_ff) begin
                  dup_in  = 1'b1;
                  dups_in = dups_ff + 32'd1;
               end else begin
                  dup_in     = 1'b0;
                  cursor_in  = offset_ff + 64'd1;
                  applied_in = applied_ff + 32'd1;
               end
               rec_last                  = (body_ff == 14'(rrr_pkg::HDR_BYTES));
               pos_in                    = rec_last ? 14'd0 : pos_ff + 14'd1;
               push_valid                = 1'b1;
               push_data.kind            = rrr_pkg::KIND_HEADER;
               push_data.status          = dup_in ? rrr_pkg::STATUS_DUPLICATE
                                                  : rrr_pkg::STATUS_NEW;
               push_data.applied_count   = applied_in;
               push_data.duplicate_count = dups_in;
               push_data.last            = rec_last;
            end
         end else begin
            rec_last           = ((pos_ff - 14'(rrr_pkg::PREFIX_BYTES - 1)) >= body_ff);
            pos_in             = rec_last ? 14'd0 : pos_ff + 14'd1;
            push_valid         = 1'b1;
            push_data.status   = dup_ff ? rrr_pkg::STATUS_DUPLICATE : rrr_pkg::STATUS_NEW;
            push_data.out_byte = req_in_byte;
            push_data.last     = rec_last;
            if (content_index < {6'b000000, type_len_ff}) begin
               push_data.kind = rrr_pkg::KIND_TYPE;
            end else if (content_index < {5'b00000, type_res_sum}) begin
               push_data.kind = rrr_pkg::KIND_RESOURCE;
            end else begin
               push_data.kind = rrr_pkg::KIND_PAYLOAD;
            end
         end

         if (do_fail) begin
            failed_in                 = 1'b1;
            push_valid                = 1'b1;
            push_data.kind            = rrr_pkg::KIND_ERROR;
            push_data.status          = fail_status;
            push_data.out_byte        = 8'h00;
            push_data.record_offset   = '0;
            push_data.event_id_high   = '0;
            push_data.event_id_low    = '0;
            push_data.payload_length  = '0;
            push_data.type_length     = '0;
            push_data.resource_length = '0;
            push_data.applied_count   = applied_ff;
            push_data.duplicate_count = dups_ff;
            push_data.last            = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peer_ff     <= 1'b0;
         max_body_ff <= 14'(rrr_pkg::MAX_BODY_RESET);
         pos_ff      <= '0;
         body_ff     <= '0;
         offset_ff   <= '0;
         id_low_ff   <= '0;
         id_high_ff  <= '0;
         pl_len_ff   <= '0;
         type_len_ff <= '0;
         res_len_ff  <= '0;
         dup_ff      <= 1'b0;
         cursor_ff   <= '0;
         applied_ff  <= '0;
         dups_ff     <= '0;
         failed_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               rrr_pkg::CSR_PEER_CONFIRMED:  peer_ff <= csr_write_data[0];
               rrr_pkg::CSR_MAX_BODY_LENGTH: max_body_ff <= csr_write_data;
               default: ;
            endcase
         end
         pos_ff      <= pos_in;
         body_ff     <= body_in;
         offset_ff   <= offset_in;
         id_low_ff   <= id_low_in;
         id_high_ff  <= id_high_in;
         pl_len_ff   <= pl_len_in;
         type_len_ff <= type_len_in;
         res_len_ff  <= res_len_in;
         dup_ff      <= dup_in;
         cursor_ff   <= cursor_in;
         applied_ff  <= applied_in;
         dups_ff     <= dups_in;
         failed_ff   <= failed_in;
      end
   end

   rrr_out_skid u_out_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (buf_full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_kind            = rsp_data.kind;
   assign rsp_status          = rsp_data.status;
   assign rsp_out_byte        = rsp_data.out_byte;
   assign rsp_record_offset   = rsp_data.record_offset;
   assign rsp_event_id_high   = rsp_data.event_id_high;
   assign rsp_event_id_low    = rsp_data.event_id_low;
   assign rsp_payload_length  = rsp_data.payload_length;
   assign rsp_type_length     = rsp_data.type_length;
   assign rsp_resource_length = rsp_data.resource_length;
   assign rsp_applied_count   = rsp_data.applied_count;
   assign rsp_duplicate_count = rsp_data.duplicate_count;
   assign rsp_last            = rsp_data.last;

   // Once failed, the session stays failed until reset.
   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff |=> failed_ff)
      else $error("failed flag cleared without reset");

   a_no_result_when_failed: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> !push_valid)
      else $error("result produced by a failed session");

   a_header_on_last_byte: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_data.kind == rrr_pkg::KIND_HEADER)
      |-> (hb == 5'(rrr_pkg::HDR_BYTES - 1)))
      else $error("header result away from the last header byte");

endmodule

>>> verif/record_stream_checker.sv
module record_stream_checker
   import rrr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_kind,
   input  logic [2:0]  rsp_status,
   input  logic [7:0]  rsp_out_byte,
   input  logic [63:0] rsp_record_offset,
   input  logic [63:0] rsp_event_id_high,
   input  logic [63:0] rsp_event_id_low,
   input  logic [10:0] rsp_payload_length,
   input  logic [5:0]  rsp_type_length,
   input  logic [7:0]  rsp_resource_length,
   input  logic [31:0] rsp_applied_count,
   input  logic [31:0] rsp_duplicate_count,
   input  logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [13:0] csr_write_data,
   output int          mismatch_count,
   output int          pending_results,
   output int          results_checked
);

   logic        cfg_peer;
   logic [13:0] cfg_max;

   logic [13:0] frame_pos;
   logic [13:0] frame_len;
   logic [63:0] hdr_offset;
   logic [63:0] hdr_id_lo;
   logic [63:0] hdr_id_hi;
   logic [15:0] hdr_pay;
   logic [7:0]  hdr_type;
   logic [7:0]  hdr_res;
   logic        dup_record;
   logic [63:0] cursor;
   logic [31:0] applied;
   logic [31:0] dups;
   logic        failed;

   result_type expected_results[$];
   int mismatches = 0;
   int checked_count = 0;

   function automatic result_type make_result(input kind_type k, input status_type s,
                                              input logic [7:0] b, input logic last);
      result_type r;
      r.kind            = k;
      r.status          = s;
      r.out_byte        = b;
      r.record_offset   = hdr_offset;
      r.event_id_high   = hdr_id_hi;
      r.event_id_low    = hdr_id_lo;
      r.payload_length  = hdr_pay[10:0];
      r.type_length     = hdr_type[5:0];
      r.resource_length = hdr_res;
      r.applied_count   = applied;
      r.duplicate_count = dups;
      r.last            = last;
      return r;
   endfunction

   task automatic fail_session(input status_type s);
      result_type r;
      failed = 1'b1;
      r = make_result(KIND_ERROR, s, 8'h00, 1'b1);
      r.record_offset   = '0;
      r.event_id_high   = '0;
      r.event_id_low    = '0;
      r.payload_length  = '0;
      r.type_length     = '0;
      r.resource_length = '0;
      expected_results.push_back(r);
   endtask

   task automatic parse_byte(input logic [7:0] b);
      int hb;
      int lim;
      int c;
      logic done_rec;
      kind_type k;
      if (failed) return;
      if (!cfg_peer) begin
         fail_session(STATUS_PEER_UNVERIFIED);
         return;
      end
      if (frame_pos < PREFIX_BYTES) begin
         if (frame_pos == 0) begin
            frame_len  = 14'(b);
            hdr_offset = '0;
            hdr_id_lo  = '0;
            hdr_id_hi  = '0;
            hdr_pay    = '0;
            hdr_type   = '0;
            hdr_res    = '0;
            dup_record = 1'b0;
         end else if (frame_len != LEN_SAT) begin
            if (frame_pos == 1 && b <= 8'h3f) begin
               frame_len = frame_len | {b[5:0], 8'h00};
            end else if (b != 8'h00) begin
               frame_len = 14'(LEN_SAT);
            end
         end
         if (frame_pos == PREFIX_BYTES - 1) begin
            lim = (cfg_max > BODY_CAP) ? int'(BODY_CAP) : int'(cfg_max);
            if (int'(frame_len) < int'(HDR_BYTES) || int'(frame_len) > lim) begin
               fail_session(STATUS_BAD_FRAME_LEN);
               return;
            end
         end
         frame_pos = frame_pos + 14'd1;
         return;
      end

      hb = int'(frame_pos) - int'(PREFIX_BYTES);
      if (hb < int'(HDR_BYTES)) begin
         if (hb < 8) hdr_offset = hdr_offset | (64'(b) << (8 * hb));
         else if (hb < 16) hdr_id_lo = hdr_id_lo | (64'(b) << (8 * (hb - 8)));
         else if (hb < 24) hdr_id_hi = hdr_id_hi | (64'(b) << (8 * (hb - 16)));
         else if (hb == 24) hdr_pay = 16'(b);
         else if (hb == 25) hdr_pay = hdr_pay | {b, 8'h00};
         else if (hb == 26) hdr_type = b;
         else if (hb == 27) hdr_res = b;
         if (hb < int'(HDR_BYTES) - 1) begin
            frame_pos = frame_pos + 14'd1;
            return;
         end
         if (hdr_pay > PAYLOAD_BYTES || hdr_type > EVENT_TYPE_MAX ||
             hdr_res >= RESOURCE_BUFFER ||
             int'(frame_len) != int'(HDR_BYTES) + int'(hdr_type) + int'(hdr_res) +
                                int'(hdr_pay)) begin
            fail_session(STATUS_MALFORMED);
            return;
         end
         // The cursor and counters move as soon as the header is complete.
         if (hdr_offset < cursor) begin
            dup_record = 1'b1;
            dups = dups + 32'd1;
         end else begin
            dup_record = 1'b0;
            cursor = hdr_offset + 64'd1;
            applied = applied + 32'd1;
         end
         done_rec = (frame_len == HDR_BYTES);
         frame_pos = done_rec ? 14'd0 : frame_pos + 14'd1;
         expected_results.push_back(make_result(KIND_HEADER,
            dup_record ? STATUS_DUPLICATE : STATUS_NEW, 8'h00, done_rec));
         return;
      end

      c = hb - int'(HDR_BYTES);
      done_rec = (hb + 1 >= int'(frame_len));
      if (c < int'(hdr_type)) k = KIND_TYPE;
      else if (c < int'(hdr_type) + int'(hdr_res)) k = KIND_RESOURCE;
      else k = KIND_PAYLOAD;
      frame_pos = done_rec ? 14'd0 : frame_pos + 14'd1;
      expected_results.push_back(make_result(k,
         dup_record ? STATUS_DUPLICATE : STATUS_NEW, b, done_rec));
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         if (mismatches < 10) begin
            $display("checker: %s mismatch, expected %0h, got %0h", name, want, got);
         end
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         cfg_peer   = 1'b0;
         cfg_max    = 14'(MAX_BODY_RESET);
         frame_pos  = '0;
         frame_len  = '0;
         hdr_offset = '0;
         hdr_id_lo  = '0;
         hdr_id_hi  = '0;
         hdr_pay    = '0;
         hdr_type   = '0;
         hdr_res    = '0;
         dup_record = 1'b0;
         cursor     = '0;
         applied    = '0;
         dups       = '0;
         failed     = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_kind, rsp_status, rsp_out_byte, rsp_record_offset,
                    rsp_event_id_high, rsp_event_id_low, rsp_payload_length,
                    rsp_type_length, rsp_resource_length, rsp_applied_count,
                    rsp_duplicate_count, rsp_last};
            if (expected_results.size() == 0) begin
               if (mismatches < 10) begin
                  $display("checker: result beat of kind %0d with nothing expected", rsp_kind);
               end
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("kind", 64'(want.kind), 64'(seen.kind));
               check_field("status", 64'(want.status), 64'(seen.status));
               check_field("out_byte", 64'(want.out_byte), 64'(seen.out_byte));
               check_field("record_offset", want.record_offset, seen.record_offset);
               check_field("event_id_high", want.event_id_high, seen.event_id_high);
               check_field("event_id_low", want.event_id_low, seen.event_id_low);
               check_field("payload_length", 64'(want.payload_length),
                           64'(seen.payload_length));
               check_field("type_length", 64'(want.type_length), 64'(seen.type_length));
               check_field("resource_length", 64'(want.resource_length),
                           64'(seen.resource_length));
               check_field("applied_count", 64'(want.applied_count),
                           64'(seen.applied_count));
               check_field("duplicate_count", 64'(want.duplicate_count),
                           64'(seen.duplicate_count));
               check_field("last", 64'(want.last), 64'(seen.last));
               checked_count++;
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_PEER_CONFIRMED) cfg_peer = csr_write_data[0];
            else cfg_max = csr_write_data;
         end
         if (req_valid && !req_stall) parse_byte(req_in_byte);
      end
      pending_results <= expected_results.size();
      mismatch_count  <= mismatches;
      results_checked <= checked_count;
   end

endmodule

>>> verif/tb.sv
module tb;
   import rrr_pkg::*;

   localparam int RANDOM_BYTES   = 880;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef enum int {
      CLOSE_UNVERIFIED,
      CLOSE_SHORT_BODY,
      CLOSE_LONG_BODY,
      CLOSE_MALFORMED,
      CLOSE_TIGHT_LIMIT
   } closing_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_out_byte;
   logic [63:0] rsp_record_offset;
   logic [63:0] rsp_event_id_high;
   logic [63:0] rsp_event_id_low;
   logic [10:0] rsp_payload_length;
   logic [5:0]  rsp_type_length;
   logic [7:0]  rsp_resource_length;
   logic [31:0] rsp_applied_count;
   logic [31:0] rsp_duplicate_count;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [13:0] csr_write_data = '0;

   int mismatch_count;
   int pending_results;
   int results_checked;

   bit          calm = 1'b0;
   int          bytes_sent = 0;
   int          records_sent = 0;
   int          repeats_sent = 0;
   int          stuck_cycles = 0;
   logic [63:0] next_offset = '0;
   logic [13:0] body_limit = 14'(MAX_BODY_RESET);

   replication_record_receiver u_top (.*);
   record_stream_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 7);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          csr_write_enable) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [13:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limit(input logic [13:0] v);
      csr_write(CSR_MAX_BODY_LENGTH, v);
      body_limit = (v > BODY_CAP) ? 14'(BODY_CAP) : v;
   endtask

   task automatic send_record(input logic [31:0] body, input logic [63:0] off,
                              input int t, input int r, input int p, input int content);
      logic [127:0] id;
      id = {$urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < 4; i++) send_byte(body[8 * i +: 8]);
      for (int i = 0; i < 8; i++) send_byte(off[8 * i +: 8]);
      for (int i = 0; i < 16; i++) send_byte(id[8 * i +: 8]);
      send_byte(8'(p));
      send_byte(8'(p >> 8));
      send_byte(8'(t));
      send_byte(8'(r));
      repeat (4) send_byte(8'($urandom));
      repeat (content) send_byte(8'($urandom));
      if (off >= next_offset) next_offset = off + 64'd1;
      else repeats_sent++;
      records_sent++;
   endtask

   function automatic logic [63:0] choose_offset();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15 && next_offset != 0) return {$urandom, $urandom} % next_offset;
      if (roll < 30) return next_offset;
      if (roll < 32) return {$urandom, $urandom};
      return next_offset + $urandom_range(1, 5000);
   endfunction

   task automatic random_record();
      int budget;
      int t;
      int r;
      int p;
      budget = int'(body_limit) - int'(HDR_BYTES);
      if ($urandom_range(99) < 3) begin
         t = $urandom_range(0, EVENT_TYPE_MAX);
         r = $urandom_range(0, RESOURCE_BUFFER - 1);
         p = $urandom_range(0, PAYLOAD_BYTES);
      end else begin
         t = $urandom_range(0, 4);
         r = $urandom_range(0, 4);
         p = $urandom_range(0, 6);
      end
      if (t > budget) t = budget;
      if (r > budget - t) r = budget - t;
      if (p > budget - t - r) p = budget - t - r;
      send_record(HDR_BYTES + t + r + p, choose_offset(), t, r, p, t + r + p);
   endtask

   initial begin
      int start;
      int phase;
      int left_in_phase;
      int roll;
      int t;
      int r;
      int p;
      logic [31:0] wild_len;
      closing_type closing;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      csr_write(CSR_PEER_CONFIRMED, 14'd1);
      set_limit(14'(MAX_BODY_RESET));
      send_record(HDR_BYTES, 64'd0, 0, 0, 0, 0);
      send_record(HDR_BYTES, 64'd0, 0, 0, 0, 0);
      send_record(HDR_BYTES + 3, 64'd7, 1, 1, 1, 3);
      send_record(HDR_BYTES + EVENT_TYPE_MAX + RESOURCE_BUFFER - 1, '1,
                  EVENT_TYPE_MAX, RESOURCE_BUFFER - 1, 0,
                  EVENT_TYPE_MAX + RESOURCE_BUFFER - 1);
      send_record(HDR_BYTES, 64'd0, 0, 0, 0, 0);
      send_record(HDR_BYTES + 3, 64'd1, 3, 0, 0, 3);
      send_record(HDR_BYTES + 2, 64'd2, 0, 2, 0, 2);
      send_record(HDR_BYTES + 4, 64'd3, 0, 0, 4, 4);
      drain_results();
      set_limit(14'(HDR_BYTES));
      send_record(HDR_BYTES, 64'd10, 0, 0, 0, 0);
      send_record(HDR_BYTES, 64'd4, 0, 0, 0, 0);

      start = bytes_sent;
      phase = 0;
      left_in_phase = 0;
      while (bytes_sent - start < RANDOM_BYTES) begin
         if (left_in_phase == 0) begin
            drain_results();
            calm = (phase == 2);
            csr_write(CSR_PEER_CONFIRMED, 14'd1);
            case (phase % 5)
               0: set_limit(14'(MAX_BODY_RESET));
               1: set_limit(14'(HDR_BYTES));
               2: set_limit(14'(LEN_SAT));
               3: set_limit(14'($urandom_range(HDR_BYTES, 1400)));
               default: set_limit(14'($urandom_range(HDR_BYTES, LEN_SAT)));
            endcase
            phase++;
            left_in_phase = 4;
         end else if ($urandom_range(99) < 3) begin
            drain_results();
         end
         random_record();
         left_in_phase--;
      end
      calm = 1'b0;

      // The block stays failed after any error, so the run closes on one of them.
      drain_results();
      closing = closing_type'($urandom_range(0, 4));
      case (closing)
         CLOSE_UNVERIFIED: begin
            csr_write(CSR_PEER_CONFIRMED, 14'd0);
            send_byte(8'($urandom));
         end
         CLOSE_SHORT_BODY: begin
            send_record($urandom_range(0, HDR_BYTES - 1), next_offset, 0, 0, 0, 0);
         end
         CLOSE_LONG_BODY: begin
            wild_len = $urandom;
            if ($urandom_range(1)) wild_len[31:16] = '0;
            if (wild_len[15:8] < 8'h21) wild_len[15:8] = 8'h21;
            send_record(wild_len, next_offset, 0, 0, 0, 0);
         end
         CLOSE_MALFORMED: begin
            set_limit(14'(MAX_BODY_RESET));
            roll = $urandom_range(99);
            if (roll < 34) begin
               t = $urandom_range(0, 4);
               r = $urandom_range(0, 4);
               p = $urandom_range(0, 6);
               send_record(HDR_BYTES + t + r + p + $urandom_range(1, 40), next_offset,
                           t, r, p, 0);
            end else if (roll < 67) begin
               send_record(HDR_BYTES + $urandom_range(0, 100), next_offset, 0, 0,
                           $urandom_range(PAYLOAD_BYTES + 1, 65535), 0);
            end else begin
               t = $urandom_range(EVENT_TYPE_MAX + 1, 255);
               send_record(HDR_BYTES + t, next_offset, t, 0, 0, 0);
            end
         end
         default: begin
            set_limit(14'($urandom_range(0, HDR_BYTES - 1)));
            send_record(HDR_BYTES, next_offset, 0, 0, 0, 0);
         end
      endcase
      drain_results();
      csr_write(CSR_PEER_CONFIRMED, 14'd1);
      repeat (8) send_byte(8'($urandom));

      drain_results();
      repeat (4) @(posedge clock);
      $display("tb: run covered %0d bytes in %0d records, %0d of them with a stale offset",
               bytes_sent, records_sent, repeats_sent);
      $display("tb: %0d results checked, session closed by %s", results_checked,
               closing.name());
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
